/* sv/crs_pkg.sv */
`timescale 1ns / 1ps

package crs_pkg;

  // Coordinate width of every edge on both channels
  localparam int CoordBits = 16;

  // Edge differences and sizes carry one extra sign bit
  localparam int DiffW = CoordBits + 1;
  // Magnitude of a difference or a size
  localparam int MagW  = CoordBits;
  // Magnitude product and rounded numerator 2*|d*s| + dw
  localparam int ProdW = 2 * CoordBits;
  localparam int NumW  = 2 * CoordBits + 1;
  // Divisor 2*dw
  localparam int DenW  = CoordBits + 1;
  // Quotient bits kept; anything larger saturates the edge anyway
  localparam int QuoW  = CoordBits + 1;
  // Final sum of source edge and signed quotient
  localparam int SumW  = QuoW + 2;

  // Scale lane depth: abs, multiply, numerator, one stage per quotient bit, sum
  localparam int LaneLat = QuoW + 4;

  // Stream payload layout
  localparam int InFields  = 12;
  localparam int OutFields = 8;
  localparam int InDataW   = ((InFields * CoordBits + 7) / 8) * 8;
  localparam int OutDataW  = ((OutFields * CoordBits + 1 + 7) / 8) * 8;

  // Signed coordinate limits
  localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

endpackage

/* sv/crs_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Valid only when num_i < den_i << QuoW; the caller flags the other case.
module crs_div import crs_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar g = 0; g < QuoW; g++) begin : g_stage
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] low_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW:0]   trial;
    logic            take;

    // First stage takes the high numerator bits as its partial remainder
    if (g == 0) begin : g_first
      assign rem_in = DenW'(num_i[NumW-1:QuoW]);
      assign den_in = den_i;
      assign low_in = num_i[QuoW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign low_in = low_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // Shift in the next numerator bit and try the subtraction
    assign trial = {rem_in, low_in[QuoW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= take ? DenW'(trial - {1'b0, den_in}) : DenW'(trial);
        den_q[g] <= den_in;
        low_q[g] <= low_in << 1;
        quo_q[g] <= {quo_in[QuoW-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

/* sv/crs_scale.sv */
`timescale 1ns / 1ps

// One source edge: src + round_half_up(delta * size / dst_size), saturated.
// Passes src through when the destination size is invalid.
module crs_scale import crs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DiffW-1:0]     delta_i,
  input  logic signed [DiffW-1:0]     size_i,
  input  logic        [MagW-1:0]      dst_size_i,
  input  logic signed [CoordBits-1:0] src_i,
  input  logic                        err_i,
  output logic signed [CoordBits-1:0] src_edge_o
);

  typedef struct packed {
    logic                 neg;
    logic                 ovf;
    logic                 err;
    logic [CoordBits-1:0] src;
  } side_t;

  // Stage A: magnitudes and result sign
  logic [DiffW-1:0]     abs_d;
  logic [DiffW-1:0]     abs_s;
  logic                 neg_d;
  logic [MagW-1:0]      mag_d_q;
  logic [MagW-1:0]      mag_s_q;
  logic                 neg_a_q;
  logic [MagW-1:0]      dw_a_q;
  logic [CoordBits-1:0] src_a_q;
  logic                 err_a_q;

  assign abs_d = delta_i[DiffW-1] ? DiffW'(-delta_i) : DiffW'(delta_i);
  assign abs_s = size_i[DiffW-1] ? DiffW'(-size_i) : DiffW'(size_i);
  assign neg_d = (delta_i[DiffW-1] ^ size_i[DiffW-1]) & (|delta_i) & (|size_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_d_q <= abs_d[MagW-1:0];
      mag_s_q <= abs_s[MagW-1:0];
      neg_a_q <= neg_d;
      dw_a_q  <= dst_size_i;
      src_a_q <= src_i;
      err_a_q <= err_i;
    end
  end

  // Stage B: magnitude product
  logic [ProdW-1:0]     prod_q;
  logic                 neg_b_q;
  logic [MagW-1:0]      dw_b_q;
  logic [CoordBits-1:0] src_b_q;
  logic                 err_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= ProdW'(mag_d_q) * ProdW'(mag_s_q);
      neg_b_q <= neg_a_q;
      dw_b_q  <= dw_a_q;
      src_b_q <= src_a_q;
      err_b_q <= err_a_q;
    end
  end

  // Stage C: numerator with rounding term (dw for positive, dw-1 for negative)
  logic [NumW-1:0]      num_q;
  logic [DenW-1:0]      den_q;
  logic                 neg_c_q;
  logic [CoordBits-1:0] src_c_q;
  logic                 err_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= {prod_q, 1'b0} + NumW'(dw_b_q) - NumW'(neg_b_q);
      den_q   <= {dw_b_q, 1'b0};
      neg_c_q <= neg_b_q;
      src_c_q <= src_b_q;
      err_c_q <= err_b_q;
    end
  end

  // Divide stages, with sign, overflow and pass-through data alongside
  logic [QuoW-1:0] quo;
  logic            ovf;
  side_t           side_q [QuoW];

  crs_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  // Quotient would not fit QuoW bits: the edge saturates
  assign ovf = {1'b0, num_q[NumW-1:QuoW]} >= den_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{neg: neg_c_q, ovf: ovf, err: err_c_q, src: src_c_q};
      for (int k = 1; k < QuoW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Final stage: apply sign, add to source edge, saturate; pass source through on error
  side_t                  tail;
  logic [QuoW-1:0]        quo_sat;
  logic signed [QuoW:0]   quo_s;
  logic signed [SumW-1:0] sum;
  logic signed [CoordBits-1:0] sum_sat;
  logic signed [CoordBits-1:0] edge_q;

  assign tail    = side_q[QuoW-1];
  assign quo_sat = tail.ovf ? '1 : quo;
  assign quo_s   = tail.neg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
  assign sum     = SumW'($signed(tail.src)) + SumW'(quo_s);

  always_comb begin
    if (sum > SumW'(CoordMax)) begin
      sum_sat = CoordMax;
    end else if (sum < SumW'(CoordMin)) begin
      sum_sat = CoordMin;
    end else begin
      sum_sat = sum[CoordBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge_q <= tail.err ? $signed(tail.src) : sum_sat;
    end
  end

  assign src_edge_o = edge_q;

endmodule

/* sv/crs_skid.sv */
`timescale 1ns / 1ps

// Output register plus one skid entry; ready is the inverted skid valid register.
module crs_skid import crs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OutDataW-1:0] in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  input  logic                out_ready_i
);

  logic                out_vld_q;
  logic                skid_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] skid_data_q;
  logic                push;
  logic                load;

  assign in_ready_o = !skid_vld_q;
  assign push       = in_valid_i && !skid_vld_q;
  assign load       = !out_vld_q || out_ready_i;

  // Move skid entry or new item into the output register; park item when stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= skid_vld_q ? skid_data_q : in_data_i;
    end else if (!skid_vld_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/clip_rect_scaled_source_top.sv */
`timescale 1ns / 1ps

// Clips a destination rectangle to a clip window and moves the edges of a
// paired source rectangle by the same changes scaled by source/destination
// size, rounded half up and saturated to the coordinate range.
// Input channel s_axis: each item is a full rectangle set (destination, clip and source edges).
// Output channel m_axis: clipped destination, adjusted source, size_error.
// Path from accept to m_axis_tvalid_o: stage 1 registers, the scale lanes and the
// output register; the divider resolves one quotient bit per pipeline stage.
// Throughput: one item per cycle; a new item is taken every cycle while the
// output side keeps up.
// Stall: the output register and a one-entry skid buffer decouple the sides;
// the pipeline freezes only once the skid entry is full, and s_axis_tready_o
// is driven straight from a register. Nothing is dropped or repeated.
// Reset: all valid bits clear, so both buffers are empty; no item is in flight and the
// block is ready as soon as reset is released.
module clip_rect_scaled_source_top import crs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // dst_top, dst_left, dst_bottom, dst_right, clip_top, clip_left,
  // clip_bottom, clip_right, src_top, src_left, src_bottom, src_right
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_dst_top, out_dst_left, out_dst_bottom, out_dst_right, out_src_top,
  // out_src_left, out_src_bottom, out_src_right, size_error, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  typedef struct packed {
    logic                 err;
    logic [CoordBits-1:0] nt;
    logic [CoordBits-1:0] nl;
    logic [CoordBits-1:0] nb;
    logic [CoordBits-1:0] nr;
  } dst_t;

  logic en;

  // Unpack input fields
  logic signed [CoordBits-1:0] dt, dl, db, dr, ct, cl, cb, cr, st, sl, sb, sr;

  assign dt = s_axis_tdata_i[0  * CoordBits +: CoordBits];
  assign dl = s_axis_tdata_i[1  * CoordBits +: CoordBits];
  assign db = s_axis_tdata_i[2  * CoordBits +: CoordBits];
  assign dr = s_axis_tdata_i[3  * CoordBits +: CoordBits];
  assign ct = s_axis_tdata_i[4  * CoordBits +: CoordBits];
  assign cl = s_axis_tdata_i[5  * CoordBits +: CoordBits];
  assign cb = s_axis_tdata_i[6  * CoordBits +: CoordBits];
  assign cr = s_axis_tdata_i[7  * CoordBits +: CoordBits];
  assign st = s_axis_tdata_i[8  * CoordBits +: CoordBits];
  assign sl = s_axis_tdata_i[9  * CoordBits +: CoordBits];
  assign sb = s_axis_tdata_i[10 * CoordBits +: CoordBits];
  assign sr = s_axis_tdata_i[11 * CoordBits +: CoordBits];

  // Clip each edge on its own and form sizes
  logic signed [CoordBits-1:0] nt, nl, nb, nr;
  logic signed [DiffW-1:0]     dw, dh, sw, sh;

  assign nl = (dl < cl) ? cl : dl;
  assign nt = (dt < ct) ? ct : dt;
  assign nr = (dr > cr) ? cr : dr;
  assign nb = (db > cb) ? cb : db;
  assign dw = DiffW'(dr) - DiffW'(dl);
  assign dh = DiffW'(db) - DiffW'(dt);
  assign sw = DiffW'(sr) - DiffW'(sl);
  assign sh = DiffW'(sb) - DiffW'(st);

  // Stage 1 registers
  logic signed [CoordBits-1:0] nt_q, nl_q, nb_q, nr_q;
  logic signed [CoordBits-1:0] st_q, sl_q, sb_q, sr_q;
  logic signed [DiffW-1:0]     del_t_q, del_l_q, del_b_q, del_r_q;
  logic signed [DiffW-1:0]     sw_q, sh_q;
  logic [MagW-1:0]             dw_q, dh_q;
  logic                        err_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nt_q    <= nt;
      nl_q    <= nl;
      nb_q    <= nb;
      nr_q    <= nr;
      st_q    <= st;
      sl_q    <= sl;
      sb_q    <= sb;
      sr_q    <= sr;
      del_t_q <= DiffW'(nt) - DiffW'(dt);
      del_l_q <= DiffW'(nl) - DiffW'(dl);
      del_b_q <= DiffW'(nb) - DiffW'(db);
      del_r_q <= DiffW'(nr) - DiffW'(dr);
      sw_q    <= sw;
      sh_q    <= sh;
      dw_q    <= dw[MagW-1:0];
      dh_q    <= dh[MagW-1:0];
      err_q   <= (dw <= 0) || (dh <= 0);
    end
  end

  // Valid bits: stage 1 then one per lane stage
  logic [LaneLat:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LaneLat-1:0], s_axis_tvalid_i};
    end
  end

  // Carry clipped destination alongside the scale lanes
  dst_t dly_q [LaneLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= '{err: err_q, nt: nt_q, nl: nl_q, nb: nb_q, nr: nr_q};
      for (int k = 1; k < LaneLat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  // Four scale lanes
  logic signed [CoordBits-1:0] os_t, os_l, os_b, os_r;

  crs_scale u_scale_top (
    .clk_i      (clk_i),
    .en_i       (en),
    .delta_i    (del_t_q),
    .size_i     (sh_q),
    .dst_size_i (dh_q),
    .src_i      (st_q),
    .err_i      (err_q),
    .src_edge_o (os_t)
  );

  crs_scale u_scale_left (
    .clk_i      (clk_i),
    .en_i       (en),
    .delta_i    (del_l_q),
    .size_i     (sw_q),
    .dst_size_i (dw_q),
    .src_i      (sl_q),
    .err_i      (err_q),
    .src_edge_o (os_l)
  );

  crs_scale u_scale_bottom (
    .clk_i      (clk_i),
    .en_i       (en),
    .delta_i    (del_b_q),
    .size_i     (sh_q),
    .dst_size_i (dh_q),
    .src_i      (sb_q),
    .err_i      (err_q),
    .src_edge_o (os_b)
  );

  crs_scale u_scale_right (
    .clk_i      (clk_i),
    .en_i       (en),
    .delta_i    (del_r_q),
    .size_i     (sw_q),
    .dst_size_i (dw_q),
    .src_i      (sr_q),
    .err_i      (err_q),
    .src_edge_o (os_r)
  );

  // Pack result item and hand it to the output buffer
  dst_t                tail;
  logic                tail_vld;
  logic [OutDataW-1:0] res_data;

  assign tail     = dly_q[LaneLat-1];
  assign tail_vld = vld_q[LaneLat];
  assign res_data = OutDataW'({tail.err, os_r, os_b, os_l, os_t,
                               tail.nr, tail.nb, tail.nl, tail.nt});

  crs_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tail_vld),
    .in_data_i   (res_data),
    .in_ready_o  (en),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign s_axis_tready_o = en;

  // The skid entry only fills when the output register was held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("skid entry filled while output was free");

  // A full skid entry implies a result waiting at the output
  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input blocked with no result pending");

  // A frozen pipeline keeps its finished item
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready_o && tail_vld) |=> tail_vld)
    else $error("pipeline tail item lost during stall");

endmodule
